// ----- design/lnds_pkg.sv -----
// Shared constants and controller/datapath interface types for the subsequence finder.
`default_nettype none

package lnds_pkg;

  localparam int unsigned SAMPLE_W        = 32;
  localparam int unsigned POS_W           = 7;
  localparam int unsigned MAX_ITEMS_DEF   = 64;
  localparam int unsigned VALUE_BITS_DEF  = 32;

  typedef struct packed {
    logic             load_we;
    logic [POS_W-1:0] rd_addr;
    logic             key_ld;
    logic             row_init;
    logic             cmp_en;
    logic [POS_W-1:0] cmp_pos;
    logic             row_wr;
    logic [POS_W-1:0] row_idx;
    logic             pass_init;
    logic             emit_ld;
    logic [POS_W-1:0] emit_pos;
    logic             emit_last;
    logic             clear;
  } lnds_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] count;
    logic [POS_W-1:0] best;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] succ;
    logic             out_free;
  } lnds_status_t;

endpackage

`default_nettype wire

// ----- design/lnds_datapath.sv -----
// Datapath: sequence stores, row compare unit, best tracker and result register.
`default_nettype none

module lnds_datapath #(
  parameter int unsigned MAX_ITEMS  = lnds_pkg::MAX_ITEMS_DEF,
  parameter int unsigned VALUE_BITS = lnds_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [lnds_pkg::SAMPLE_W-1:0] sample_value_i,
  input  lnds_pkg::lnds_cmd_t                 cmd_i,
  output lnds_pkg::lnds_status_t              status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lnds_pkg::SAMPLE_W-1:0] element_value_o,
  output logic [lnds_pkg::POS_W-1:0]          element_position_o,
  output logic [lnds_pkg::POS_W-1:0]          best_length_o,
  output logic                                run_end_o,
  output logic                                overflow_seen_o
);
  import lnds_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned VB = VALUE_BITS;

  logic signed [VB-1:0] val_mem [MAX_ITEMS];
  logic [CW-1:0]        rl_mem  [MAX_ITEMS];
  logic [CW-1:0]        sc_mem  [MAX_ITEMS];

  logic signed [VB-1:0] val_rd_q;
  logic [CW-1:0]        rl_rd_q;
  logic [CW-1:0]        sc_rd_q;

  logic signed [VB-1:0] key_q, key_d;
  logic [CW-1:0]        len_q, len_d;
  logic [CW-1:0]        succ_q, succ_d;
  logic [CW-1:0]        best_q, best_d;
  logic [AW-1:0]        start_q, start_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;

  logic signed [SAMPLE_W-1:0] ev_q;
  logic [POS_W-1:0]           epos_q;
  logic [POS_W-1:0]           blen_q;
  logic                       rend_q;
  logic                       eovf_q;

  logic signed [VB-1:0] in_val;
  logic                 store_full;
  logic                 val_we;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        row_addr;
  logic                 take;

  assign in_val     = VB'(sample_value_i);
  assign store_full = (count_q == CW'(MAX_ITEMS));
  assign val_we     = cmd_i.load_we && !store_full;
  assign rd_addr    = cmd_i.rd_addr[AW-1:0];
  assign row_addr   = cmd_i.row_idx[AW-1:0];
  assign take       = (len_q <= rl_rd_q) && (val_rd_q >= key_q);

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[count_q[AW-1:0]] <= in_val;
    end
    val_rd_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_wr) begin
      rl_mem[row_addr] <= len_q;
      sc_mem[row_addr] <= succ_q;
    end
    rl_rd_q <= rl_mem[rd_addr];
    sc_rd_q <= sc_mem[rd_addr];
  end

  always_comb begin
    key_d   = key_q;
    len_d   = len_q;
    succ_d  = succ_q;
    best_d  = best_q;
    start_d = start_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.load_we) begin
      if (store_full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
    if (cmd_i.key_ld) begin
      key_d = val_rd_q;
    end
    if (cmd_i.row_init) begin
      len_d  = CW'(1);
      succ_d = '0;
    end
    if (cmd_i.cmp_en && take) begin
      len_d  = rl_rd_q + CW'(1);
      succ_d = cmd_i.cmp_pos[CW-1:0];
    end
    if (cmd_i.pass_init) begin
      best_d  = '0;
      start_d = '0;
    end
    if (cmd_i.row_wr && (len_q >= best_q)) begin
      best_d  = len_q;
      start_d = row_addr;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit_ld) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    len_q   <= len_d;
    succ_q  <= succ_d;
    best_q  <= best_d;
    start_q <= start_d;
    if (cmd_i.emit_ld) begin
      ev_q   <= SAMPLE_W'($unsigned(val_rd_q));
      epos_q <= cmd_i.emit_pos;
      blen_q <= POS_W'(best_q);
      rend_q <= cmd_i.emit_last;
      eovf_q <= ovf_q;
    end
  end

  assign status_o.count    = POS_W'(count_q);
  assign status_o.best     = POS_W'(best_q);
  assign status_o.start    = POS_W'(start_q);
  assign status_o.succ     = POS_W'(sc_rd_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign element_value_o    = ev_q;
  assign element_position_o = epos_q;
  assign best_length_o      = blen_q;
  assign run_end_o          = rend_q;
  assign overflow_seen_o    = eovf_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("stored count exceeds depth");

  a_row_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.row_wr |-> (len_q != '0) &&
      (({1'b0, len_q} + (CW+1)'(row_addr)) <= {1'b0, count_q}))
    else $error("row length out of range");
`endif

endmodule

`default_nettype wire

// ----- design/lnds_controller.sv -----
// Controller: load, backward pass sequencing and subsequence emission.
`default_nettype none

module lnds_controller #(
  parameter int unsigned MAX_ITEMS = lnds_pkg::MAX_ITEMS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   final_item_i,
  input  lnds_pkg::lnds_status_t status_i,
  output lnds_pkg::lnds_cmd_t    cmd_o
);
  import lnds_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_ROW_RD   = 4'd2;
  localparam logic [3:0] S_ROW_KEY  = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_ROW_WR   = 4'd5;
  localparam logic [3:0] S_EMIT_SEL = 4'd6;
  localparam logic [3:0] S_EMIT_RD  = 4'd7;
  localparam logic [3:0] S_EMIT_LD  = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic          iss_q, iss_d;
  logic [AW-1:0] iss_pos_q, iss_pos_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [CW-1:0] k_q, k_d;

  logic [CW-1:0] n;
  logic          last;

  assign n    = status_i.count[CW-1:0];
  assign last = ((POS_W'(k_q) + POS_W'(1)) == status_i.best) || (status_i.succ == '0);

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    iss_d     = iss_q;
    iss_pos_d = iss_pos_q;
    cur_d     = cur_q;
    k_d       = k_q;
    cmd_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_we = 1'b1;
          if (final_item_i) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.pass_init = 1'b1;
        i_d     = AW'(status_i.count - POS_W'(1));
        state_d = S_ROW_RD;
      end
      S_ROW_RD: begin
        cmd_o.rd_addr = POS_W'(i_q);
        state_d       = S_ROW_KEY;
      end
      S_ROW_KEY: begin
        cmd_o.key_ld   = 1'b1;
        cmd_o.row_init = 1'b1;
        j_d     = CW'(i_q) + CW'(1);
        iss_d   = 1'b0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.cmp_en  = iss_q;
        cmd_o.cmp_pos = POS_W'(iss_pos_q) + POS_W'(1);
        if (j_q < n) begin
          cmd_o.rd_addr = POS_W'(j_q);
          iss_d     = 1'b1;
          iss_pos_d = j_q[AW-1:0];
          j_d       = j_q + CW'(1);
        end else begin
          iss_d = 1'b0;
          if (!iss_q) begin
            state_d = S_ROW_WR;
          end
        end
      end
      S_ROW_WR: begin
        cmd_o.row_wr  = 1'b1;
        cmd_o.row_idx = POS_W'(i_q);
        if (i_q == '0) begin
          state_d = S_EMIT_SEL;
        end else begin
          i_d     = i_q - AW'(1);
          state_d = S_ROW_RD;
        end
      end
      S_EMIT_SEL: begin
        cur_d   = status_i.start[AW-1:0];
        k_d     = '0;
        state_d = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        cmd_o.rd_addr = POS_W'(cur_q);
        state_d       = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd_o.rd_addr = POS_W'(cur_q);
        if (status_i.out_free) begin
          cmd_o.emit_ld   = 1'b1;
          cmd_o.emit_pos  = POS_W'(cur_q) + POS_W'(1);
          cmd_o.emit_last = last;
          if (last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_LOAD;
          end else begin
            cur_d   = AW'(status_i.succ - POS_W'(1));
            k_d     = k_q + CW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      iss_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    j_q       <= j_d;
    iss_pos_q <= iss_pos_d;
    cur_q     <= cur_d;
    k_q       <= k_d;
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_ld |-> status_i.out_free)
    else $error("result loaded while output register busy");

  a_scan_after_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && iss_q |-> (iss_pos_q > i_q))
    else $error("compare position not after current row");

  a_pass_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> (status_i.count != '0))
    else $error("backward pass started on empty sequence");
`endif

endmodule

`default_nettype wire

// ----- design/longest_nondecreasing_subsequence.sv -----
// Loading accepts one item per cycle. After the final item a setup state runs, then rows
// n-1 down to 0 are each read, given their key, compared with every later item and written back.
// Emission: select state, then read and load states per element; loads wait on output stall.
// Throughput: one sequence at a time; the next load starts once the last result is registered.
// Reset clears the controller state, the fill count and the overflow flag; the stores are
// not cleared and are always written before their contents are used.
`default_nettype none

module longest_nondecreasing_subsequence #(
  parameter int unsigned MAX_ITEMS  = lnds_pkg::MAX_ITEMS_DEF,
  parameter int unsigned VALUE_BITS = lnds_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lnds_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic                                final_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lnds_pkg::SAMPLE_W-1:0] element_value_o,
  output logic [lnds_pkg::POS_W-1:0]          element_position_o,
  output logic [lnds_pkg::POS_W-1:0]          best_length_o,
  output logic                                run_end_o,
  output logic                                overflow_seen_o
);
  import lnds_pkg::*;

  lnds_cmd_t    cmd;
  lnds_status_t status;

  lnds_controller #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .final_item_i(final_item_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lnds_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sample_value_i    (sample_value_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .element_value_o   (element_value_o),
    .element_position_o(element_position_o),
    .best_length_o     (best_length_o),
    .run_end_o         (run_end_o),
    .overflow_seen_o   (overflow_seen_o)
  );

endmodule

`default_nettype wire
